/* src/sprite_animation_sequencer_macros.svh */
// Assertion macros for the checker file.
// Each expects clk and rst_n to be visible where it is used.
`ifndef SPRITE_ANIMATION_SEQUENCER_MACROS_SVH
`define SPRITE_ANIMATION_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SAS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, disabled during reset
`define SAS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

/* src/sas_pkg.sv */
package sas_pkg;

    // Defaults and fixed sizes
    localparam int NUM_STATES_DEF = 16;
    localparam int MAX_FRAMES     = 64;
    localparam int STATE_SPAN     = 16;   // ids reachable through a 4-bit state number
    localparam int REWIND_W       = 16;
    localparam int IN_DATA_W      = 72;
    localparam int OUT_DATA_W     = 24;
    localparam int CMD_W          = 2;

    localparam logic [6:0]        FRAME_CAP = 7'(MAX_FRAMES);
    localparam logic signed [4:0] NO_STATE  = -5'sd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 2'd0,
        CMD_CHANGE = 2'd1,
        CMD_DEFINE = 2'd2,
        CMD_REWIND = 2'd3
    } sas_cmd_t;

    // Stored animation-state descriptor
    typedef struct packed {
        logic [15:0]        frame_interval;
        logic signed [15:0] rep_total;
        logic               ping_pong;
        logic signed [4:0]  follow_state;
        logic [6:0]         frame_total;
        logic [5:0]         head_frame;
    } sas_desc_t;

    // One input item
    typedef struct packed {
        sas_cmd_t           command;
        logic [3:0]         state_id;
        logic [15:0]        frame_interval;
        logic signed [15:0] repeat_total;
        logic               ping_pong;
        logic signed [4:0]  follow_state;
        logic [6:0]         frame_total;
        logic [5:0]         head_frame;
        logic [15:0]        rewind_set;
    } sas_item_t;

    // One result item
    typedef struct packed {
        logic signed [4:0] shown_state;
        logic signed [4:0] pending_state;
        logic [5:0]        frame_index;
        logic              finished;
        logic              bad_state;
    } sas_result_t;

    // Table write request from the engine
    typedef struct packed {
        logic                desc_en;
        logic                rew_en;
        logic [3:0]          slot;
        sas_desc_t           desc;
        logic [REWIND_W-1:0] rew;
    } sas_wr_t;

endpackage

/* src/sas_tables.sv */
module sas_tables
    import sas_pkg::*;
#(
    parameter int NUM_STATES = NUM_STATES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  sas_wr_t             wr,
    input  logic [3:0]          rd_state,
    output logic                rd_defined,
    output sas_desc_t           rd_desc,
    output logic [REWIND_W-1:0] rd_rewind
);

    localparam int NUM_SLOTS = (NUM_STATES < STATE_SPAN) ? NUM_STATES : STATE_SPAN;
    localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    sas_desc_t           desc_reg  [NUM_SLOTS];
    logic [REWIND_W-1:0] rew_reg   [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] valid_reg;

    logic             wr_hit;
    logic [IDX_W-1:0] wr_idx;
    logic             rd_hit;
    logic [IDX_W-1:0] rd_idx;

    // Slot decode; slots past the table count as undefined
    assign wr_hit = int'(wr.slot) < NUM_SLOTS;
    assign wr_idx = wr.slot[IDX_W-1:0];
    assign rd_hit = int'(rd_state) < NUM_SLOTS;
    assign rd_idx = rd_state[IDX_W-1:0];

    // Descriptor storage, no reset; valid bits mark written slots
    always_ff @(posedge clk)
    begin
        if (wr.desc_en && wr_hit)
        begin
            desc_reg[wr_idx] <= wr.desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                rew_reg[i] <= '0;
            end
        end
        else
        begin
            if (wr.desc_en && wr_hit)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (wr.rew_en && wr_hit)
            begin
                rew_reg[wr_idx] <= wr.rew;
            end
        end
    end

    // Single read port
    assign rd_defined = rd_hit && valid_reg[rd_idx];
    assign rd_desc    = rd_hit ? desc_reg[rd_idx] : '0;
    assign rd_rewind  = rd_hit ? rew_reg[rd_idx] : '0;

endmodule

/* src/sas_engine.sv */
module sas_engine
    import sas_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  sas_item_t           item,
    output logic [3:0]          rd_state,
    input  logic                rd_defined,
    input  sas_desc_t           rd_desc,
    input  logic [REWIND_W-1:0] rd_rewind,
    output sas_wr_t             wr,
    output sas_result_t         result
);

    // Sequencer state, with local copies of the running and awaited descriptors
    typedef struct packed {
        logic signed [4:0]   active;
        logic signed [4:0]   awaited;
        logic [6:0]          pos;
        logic [15:0]         wait_cnt;
        logic signed [15:0]  reps;
        logic                backward;
        logic                head_passed;
        logic                done;
        sas_desc_t           cur_desc;
        logic [REWIND_W-1:0] cur_rew;
        sas_desc_t           await_desc;
        logic [REWIND_W-1:0] await_rew;
    } sas_state_t;

    localparam sas_state_t RESET_STATE = '{
        active:      NO_STATE,
        awaited:     NO_STATE,
        pos:         '0,
        wait_cnt:    '0,
        reps:        '0,
        backward:    1'b0,
        head_passed: 1'b0,
        done:        1'b0,
        cur_desc:    '0,
        cur_rew:     '0,
        await_desc:  '0,
        await_rew:   '0
    };

    sas_state_t        st_reg;
    sas_state_t        st_next;
    sas_state_t        st_tick;
    sas_state_t        req_base;
    sas_state_t        req_st;
    logic              req_ok;
    logic              fin;
    logic              bad;
    logic signed [8:0] ni;
    logic signed [8:0] pos_s;
    logic signed [8:0] total_s;
    logic signed [8:0] head_s;
    logic [6:0]        def_total;
    logic [5:0]        def_head;
    sas_desc_t         def_desc;

    function automatic sas_state_t enter_state(
        input sas_state_t          st,
        input logic [3:0]          tgt,
        input sas_desc_t           d,
        input logic [REWIND_W-1:0] rew
    );
        sas_state_t r;
        r             = st;
        r.active      = $signed({1'b0, tgt});
        r.awaited     = NO_STATE;
        r.head_passed = 1'b0;
        r.pos         = '0;
        r.backward    = 1'b0;
        r.done        = 1'b0;
        r.reps        = d.rep_total;
        r.wait_cnt    = d.frame_interval;
        r.cur_desc    = d;
        r.cur_rew     = rew;
        return r;
    endfunction

    // Change request; returns 0 for an undefined target unless awaiting or in it
    function automatic logic request_change(
        input  sas_state_t          st,
        input  logic [3:0]          tgt,
        input  logic                tgt_def,
        input  sas_desc_t           d,
        input  logic [REWIND_W-1:0] rew,
        output sas_state_t          r
    );
        logic rewind;
        logic ok;
        r      = st;
        ok     = 1'b1;
        rewind = 1'b0;
        if (st.awaited != NO_STATE || st.active == $signed({1'b0, tgt}))
        begin
            ok = 1'b1;
        end
        else if (!tgt_def)
        begin
            ok = 1'b0;
        end
        else
        begin
            if (!st.active[4])
            begin
                rewind = st.cur_rew[tgt];
            end
            if (!rewind || st.pos == '0)
            begin
                r = enter_state(st, tgt, d, rew);
            end
            else
            begin
                r.awaited     = $signed({1'b0, tgt});
                r.await_desc  = d;
                r.await_rew   = rew;
                r.wait_cnt    = d.frame_interval;
                r.head_passed = (st.pos <= {1'b0, d.head_frame}) || d.ping_pong;
            end
        end
        return ok;
    endfunction

    // Descriptor as written by a define item: clamp frame count and head
    always_comb
    begin
        def_total = (item.frame_total > FRAME_CAP) ? FRAME_CAP : item.frame_total;
        if ({1'b0, item.head_frame} >= def_total)
        begin
            def_head = (def_total == '0) ? '0 : 6'(def_total - 7'd1);
        end
        else
        begin
            def_head = item.head_frame;
        end
        def_desc.frame_interval = item.frame_interval;
        def_desc.rep_total      = item.repeat_total;
        def_desc.ping_pong      = item.ping_pong;
        def_desc.follow_state   = item.follow_state;
        def_desc.frame_total    = def_total;
        def_desc.head_frame     = def_head;
    end

    // Table traffic: one lookup, one write
    assign rd_state = (item.command == CMD_CHANGE) ? item.state_id
                                                   : st_reg.cur_desc.follow_state[3:0];

    always_comb
    begin
        wr.desc_en = fire && (item.command == CMD_DEFINE);
        wr.rew_en  = fire && (item.command == CMD_REWIND);
        wr.slot    = item.state_id;
        wr.desc    = def_desc;
        wr.rew     = item.rewind_set;
    end

    // One animation tick
    always_comb
    begin
        st_tick = st_reg;
        fin     = 1'b0;
        pos_s   = $signed({2'b00, st_reg.pos});
        total_s = $signed({2'b00, st_reg.cur_desc.frame_total});
        head_s  = $signed({3'b000, st_reg.cur_desc.head_frame});
        ni      = '0;
        if (!st_reg.active[4])
        begin
            if (st_reg.awaited != NO_STATE)
            begin
                // wrap to the head if needed, then rewind to frame 0 and switch
                if (st_reg.wait_cnt != '0)
                begin
                    st_tick.wait_cnt = st_reg.wait_cnt - 16'd1;
                end
                else if (st_reg.head_passed)
                begin
                    if (st_reg.pos == '0)
                    begin
                        st_tick = enter_state(st_reg, st_reg.awaited[3:0],
                                              st_reg.await_desc, st_reg.await_rew);
                    end
                    else
                    begin
                        st_tick.pos      = st_reg.pos - 7'd1;
                        st_tick.wait_cnt = st_reg.cur_desc.frame_interval;
                    end
                end
                else if ({1'b0, st_reg.pos} + 8'd1 >= {1'b0, st_reg.cur_desc.frame_total})
                begin
                    st_tick.pos         = {1'b0, st_reg.cur_desc.head_frame};
                    st_tick.head_passed = 1'b1;
                end
                else
                begin
                    st_tick.pos = st_reg.pos + 7'd1;
                end
            end
            else if (!st_reg.done)
            begin
                if (st_reg.wait_cnt != '0)
                begin
                    st_tick.wait_cnt = st_reg.wait_cnt - 16'd1;
                end
                else
                begin
                    ni = st_reg.backward ? pos_s - 9'sd1 : pos_s + 9'sd1;
                    if (ni >= total_s)
                    begin
                        // ran off the end
                        ni = ni - 9'sd1;
                        if (ni < 9'sd0)
                        begin
                            ni = '0;
                        end
                        if (st_reg.cur_desc.ping_pong)
                        begin
                            st_tick.backward = 1'b1;
                            if (ni > 9'sd0)
                            begin
                                ni = ni - 9'sd1;
                            end
                            st_tick.wait_cnt = st_reg.cur_desc.frame_interval;
                        end
                        else if (st_reg.reps != '0)
                        begin
                            if (!st_reg.reps[15])
                            begin
                                st_tick.reps = st_reg.reps - 16'sd1;
                            end
                            ni               = head_s;
                            st_tick.wait_cnt = st_reg.cur_desc.frame_interval;
                        end
                        else
                        begin
                            fin = 1'b1;
                        end
                    end
                    else if (st_reg.head_passed && ni < head_s)
                    begin
                        // came back below the head on the way down
                        ni = head_s;
                        if (st_reg.reps != '0)
                        begin
                            if (!st_reg.reps[15])
                            begin
                                st_tick.reps = st_reg.reps - 16'sd1;
                            end
                            st_tick.backward = 1'b0;
                            ni               = ni + 9'sd1;
                            if (ni >= total_s)
                            begin
                                ni = '0;
                            end
                            st_tick.wait_cnt = st_reg.cur_desc.frame_interval;
                        end
                        else
                        begin
                            fin = 1'b1;
                        end
                    end
                    else
                    begin
                        if (ni < 9'sd0)
                        begin
                            ni = '0;
                        end
                        st_tick.wait_cnt = st_reg.cur_desc.frame_interval;
                        if (!st_reg.head_passed && ni >= head_s)
                        begin
                            st_tick.head_passed = 1'b1;
                        end
                    end
                    st_tick.pos = ni[6:0];
                end
            end
        end
    end

    // Shared change request: from a change item or from the end of a state
    always_comb
    begin
        req_base = (item.command == CMD_CHANGE) ? st_reg : st_tick;
        req_ok   = request_change(req_base, rd_state, rd_defined, rd_desc, rd_rewind, req_st);
    end

    // Next state per command
    always_comb
    begin
        st_next = st_reg;
        bad     = 1'b0;
        case (item.command)
            CMD_TICK:
            begin
                st_next = st_tick;
                if (fin)
                begin
                    if (st_reg.cur_desc.follow_state[4])
                    begin
                        st_next.done = 1'b1;
                    end
                    else if (req_ok)
                    begin
                        st_next = req_st;
                    end
                    else
                    begin
                        st_next.done = 1'b1;
                        bad          = 1'b1;
                    end
                end
            end
            CMD_CHANGE:
            begin
                if (req_ok)
                begin
                    st_next = req_st;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            CMD_DEFINE:
            begin
                // redefinition applies at once to the running and awaited copies
                if (st_reg.active == $signed({1'b0, item.state_id}))
                begin
                    st_next.cur_desc = def_desc;
                end
                if (st_reg.awaited == $signed({1'b0, item.state_id}))
                begin
                    st_next.await_desc = def_desc;
                end
            end
            CMD_REWIND:
            begin
                if (st_reg.active == $signed({1'b0, item.state_id}))
                begin
                    st_next.cur_rew = item.rewind_set;
                end
                if (st_reg.awaited == $signed({1'b0, item.state_id}))
                begin
                    st_next.await_rew = item.rewind_set;
                end
            end
            default:
            begin
                st_next = st_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= RESET_STATE;
        end
        else if (fire)
        begin
            st_reg <= st_next;
        end
    end

    // Result reflects the state after this item
    always_comb
    begin
        result.shown_state   = st_next.active;
        result.pending_state = st_next.awaited;
        result.frame_index   = st_next.pos[5:0];
        result.finished      = st_next.done;
        result.bad_state     = bad;
    end

endmodule

/* src/sprite_animation_sequencer.sv */
// Sprite animation sequencer: frame sequencer for one animated sprite.
// Input stream s_*: one command per transaction (tuser = command: tick,
// change state, define descriptor, define back-to set); tdata carries the
// state number and descriptor fields. Output stream m_*: exactly one result
// transaction per input transaction, in order, with the current state,
// pending state, frame index, finished and bad-state flags.
// An accepted item is held in the input register, then one pass of sequencer
// logic writes its result into the result register.
// Throughput: 1 item per cycle while m_tready is high; the descriptor table
// is read at one slot per item and the sequencer state updates in that same
// cycle.
// When m_tready is low the result register holds its transaction; at most one
// more item is taken into the input register, then s_tready drops until the
// result is taken.
// Reset (rst_n low, asynchronous) clears all descriptor slots to undefined,
// all back-to sets to zero, and the sequencer to no state and frame 0. No
// clearing pass: the block takes items from the first cycle after reset.
module sprite_animation_sequencer
    import sas_pkg::*;
#(
    parameter int NUM_STATES = NUM_STATES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [3:0] state_id, [19:4] frame_interval, [35:20] repeat_total, [36] ping_pong,
    // [41:37] follow_state, [48:42] frame_total, [54:49] head_frame,
    // [70:55] rewind_set, [71] zero
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // [1:0] command
    input  logic [CMD_W-1:0]      s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [4:0] shown_state, [9:5] pending_state, [15:10] frame_index,
    // [16] finished, [17] bad_state, [23:18] zero
    output logic [OUT_DATA_W-1:0] m_tdata
);

    logic                in_vld_reg;
    logic                in_vld_next;
    sas_item_t           in_item_reg;
    logic                out_vld_reg;
    logic                out_vld_next;
    sas_result_t         out_res_reg;
    logic                s_accept;
    logic                advance;
    sas_item_t           in_item;
    sas_result_t         result;
    sas_wr_t             wr;
    logic [3:0]          rd_state;
    logic                rd_defined;
    sas_desc_t           rd_desc;
    logic [REWIND_W-1:0] rd_rewind;

    // Unpack the input transaction
    always_comb
    begin
        in_item.command        = sas_cmd_t'(s_tuser);
        in_item.state_id       = s_tdata[3:0];
        in_item.frame_interval = s_tdata[19:4];
        in_item.repeat_total   = $signed(s_tdata[35:20]);
        in_item.ping_pong      = s_tdata[36];
        in_item.follow_state   = $signed(s_tdata[41:37]);
        in_item.frame_total    = s_tdata[48:42];
        in_item.head_frame     = s_tdata[54:49];
        in_item.rewind_set     = s_tdata[70:55];
    end

    // Handshake: item moves on when the result register is free or draining
    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (s_accept)
        begin
            in_vld_next = 1'b1;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end
        out_vld_next = out_vld_reg;
        if (advance)
        begin
            out_vld_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_item_reg <= in_item;
        end
        if (advance)
        begin
            out_res_reg <= result;
        end
    end

    sas_tables #(
        .NUM_STATES (NUM_STATES)
    ) u_tables (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (wr),
        .rd_state   (rd_state),
        .rd_defined (rd_defined),
        .rd_desc    (rd_desc),
        .rd_rewind  (rd_rewind)
    );

    sas_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (advance),
        .item       (in_item_reg),
        .rd_state   (rd_state),
        .rd_defined (rd_defined),
        .rd_desc    (rd_desc),
        .rd_rewind  (rd_rewind),
        .wr         (wr),
        .result     (result)
    );

    // Pack the output transaction
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'b000000,
                       out_res_reg.bad_state,
                       out_res_reg.finished,
                       out_res_reg.frame_index,
                       out_res_reg.pending_state,
                       out_res_reg.shown_state};

endmodule

/* src/sas_checker.sv */
`include "sprite_animation_sequencer_macros.svh"

module sas_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // A stalled result holds its value
    `SAS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // Input side is never blocked while the result register can move
    `SAS_ASSERT_NOW(a_ready_free, !m_tvalid || m_tready, s_tready)

    // Shown and pending states are either none or a valid id
    `SAS_ASSERT_NOW(a_state_range, m_tvalid,
        (m_tdata[4] == 1'b0 || m_tdata[4:0] == 5'h1f) &&
        (m_tdata[9] == 1'b0 || m_tdata[9:5] == 5'h1f))

    // A pending state needs a running state and differs from it
    `SAS_ASSERT_NOW(a_pending_state, m_tvalid && m_tdata[9:5] != 5'h1f,
        m_tdata[4:0] != 5'h1f && m_tdata[4:0] != m_tdata[9:5])

endmodule

bind sprite_animation_sequencer sas_checker u_sas_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
